// ===== sv/kms_pkg.sv =====
// Package for the key matrix scanner: operation codes, command type and key map.
// Used by the front, queue, back and top-level modules of the key matrix scanner; depends on nothing.
`default_nettype none

package kms_pkg;

  localparam int NumColumns   = 5;
  localparam int ColIdxW      = $clog2(NumColumns);
  localparam int QueueDepthDf = 2;

  localparam logic [8:0] KeyBack   = 9'd8;
  localparam logic [8:0] KeyReturn = 9'd13;
  localparam logic [8:0] KeySpace  = 9'd32;
  localparam logic [8:0] KeyShift  = 9'd306;
  localparam logic [8:0] KeyCtrl   = 9'd308;
  localparam logic [8:0] KeyLeft   = 9'd314;
  localparam logic [8:0] KeyUp     = 9'd315;
  localparam logic [8:0] KeyRight  = 9'd316;
  localparam logic [8:0] KeyDown   = 9'd317;

  localparam logic [7:0] ColIdle = 8'hff;

  typedef enum logic [1:0] {
    OP_KEY_DOWN  = 2'd0,
    OP_KEY_UP    = 2'd1,
    OP_PORT_READ = 2'd2,
    OP_RESET_ALL = 2'd3
  } op_t;

  typedef struct packed {
    logic               hit;
    logic [ColIdxW-1:0] col;
    logic [7:0]         mask;
  } key_map_t;

  typedef struct packed {
    op_t                op;
    logic               shift_key;
    logic               ctrl_key;
    key_map_t           key;
    logic               port_hit;
    logic [ColIdxW-1:0] port_col;
    logic               release_col;
  } cmd_t;

  // col is the zero-based column index
  function automatic key_map_t key_lookup(input logic [8:0] code);
    key_map_t km;
    km = '{hit: 1'b0, col: '0, mask: ColIdle};
    case (code)
      9'd49: km = '{1'b1, 3'd4, 8'hfe};
      9'd50: km = '{1'b1, 3'd3, 8'hfe};
      9'd51: km = '{1'b1, 3'd2, 8'hfe};
      9'd52: km = '{1'b1, 3'd1, 8'hfe};
      9'd53: km = '{1'b1, 3'd0, 8'hfe};
      9'd81: km = '{1'b1, 3'd4, 8'hfd};
      9'd87: km = '{1'b1, 3'd3, 8'hfd};
      9'd69: km = '{1'b1, 3'd2, 8'hfd};
      9'd82: km = '{1'b1, 3'd1, 8'hfd};
      9'd84: km = '{1'b1, 3'd0, 8'hfd};
      9'd65: km = '{1'b1, 3'd4, 8'hfb};
      9'd83: km = '{1'b1, 3'd3, 8'hfb};
      9'd68: km = '{1'b1, 3'd2, 8'hfb};
      9'd70: km = '{1'b1, 3'd1, 8'hfb};
      9'd71: km = '{1'b1, 3'd0, 8'hfb};
      9'd90: km = '{1'b1, 3'd4, 8'hf7};
      9'd88: km = '{1'b1, 3'd3, 8'hf7};
      9'd67: km = '{1'b1, 3'd2, 8'hf7};
      9'd86: km = '{1'b1, 3'd1, 8'hf7};
      9'd66: km = '{1'b1, 3'd0, 8'hf7};
      9'd54: km = '{1'b1, 3'd0, 8'h7f};
      9'd55: km = '{1'b1, 3'd1, 8'h7f};
      9'd56: km = '{1'b1, 3'd2, 8'h7f};
      9'd57: km = '{1'b1, 3'd3, 8'h7f};
      9'd48: km = '{1'b1, 3'd4, 8'h7f};
      9'd89: km = '{1'b1, 3'd0, 8'hbf};
      9'd85: km = '{1'b1, 3'd1, 8'hbf};
      9'd73: km = '{1'b1, 3'd2, 8'hbf};
      KeyUp: km = '{1'b1, 3'd2, 8'hbf};
      9'd79: km = '{1'b1, 3'd3, 8'hbf};
      9'd80: km = '{1'b1, 3'd4, 8'hbf};
      9'd72: km = '{1'b1, 3'd0, 8'hdf};
      9'd74: km = '{1'b1, 3'd1, 8'hdf};
      KeyLeft: km = '{1'b1, 3'd1, 8'hdf};
      9'd75: km = '{1'b1, 3'd2, 8'hdf};
      KeyRight: km = '{1'b1, 3'd2, 8'hdf};
      9'd76: km = '{1'b1, 3'd3, 8'hdf};
      KeyReturn: km = '{1'b1, 3'd4, 8'hdf};
      9'd78: km = '{1'b1, 3'd0, 8'hef};
      9'd77: km = '{1'b1, 3'd1, 8'hef};
      KeyDown: km = '{1'b1, 3'd1, 8'hef};
      9'd46: km = '{1'b1, 3'd2, 8'hef};
      KeySpace: km = '{1'b1, 3'd3, 8'hef};
      KeyBack: km = '{1'b1, 3'd4, 8'hef};
      default: km = '{hit: 1'b0, col: '0, mask: ColIdle};
    endcase
    return km;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kms_front.sv =====
// Front end of the key matrix scanner: decodes an incoming item into a command.
// Depends on kms_pkg.
`default_nettype none

module kms_front import kms_pkg::*; (
  input  wire logic [1:0] operation,
  input  wire logic [8:0] key_code,
  input  wire logic [2:0] port_number,
  input  wire logic [3:0] cpu_reg3_top_nibble,
  output cmd_t            cmd
);

  always_comb begin
    cmd             = '0;
    cmd.op          = op_t'(operation);
    cmd.shift_key   = (key_code == KeyShift);
    cmd.ctrl_key    = (key_code == KeyCtrl);
    cmd.key         = key_lookup(key_code);
    cmd.port_hit    = port_number inside {[3'd1:3'd5]};
    cmd.port_col    = ColIdxW'(port_number - 3'd1);
    cmd.release_col = (cpu_reg3_top_nibble == 4'd0);
  end

endmodule

`default_nettype wire

// ===== sv/kms_queue.sv =====
// Short command queue between the front and back ends of the key matrix scanner.
// Depends on kms_pkg.
`default_nettype none

module kms_queue import kms_pkg::*; #(
  parameter int Depth = QueueDepthDf
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kms_back.sv =====
// Back end of the key matrix scanner: column and line state, result register.
// Depends on kms_pkg.
`default_nettype none

module kms_back import kms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_ready,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      result_valid,
  input  wire logic result_stall,
  output logic [7:0] read_data,
  output logic      control_line,
  output logic      shift_line
);

  logic [7:0] columns      [NumColumns];
  logic [7:0] columns_next [NumColumns];
  logic       control_level;
  logic       control_next;
  logic       shift_level;
  logic       shift_next;
  logic [7:0] data_next;

  assign cmd_take = cmd_ready && !(result_valid && result_stall);

  always_comb begin
    columns_next = columns;
    control_next = control_level;
    shift_next   = shift_level;
    data_next    = ColIdle;
    case (cmd.op)
      OP_KEY_DOWN: begin
        if (cmd.shift_key) begin
          shift_next = 1'b0;
        end else if (cmd.ctrl_key) begin
          control_next = 1'b0;
        end else if (cmd.key.hit) begin
          columns_next[cmd.key.col] = columns[cmd.key.col] & cmd.key.mask;
        end
      end
      OP_KEY_UP: begin
        for (int i = 0; i < NumColumns; i++) columns_next[i] = ColIdle;
        if (cmd.shift_key) begin
          shift_next = 1'b1;
        end else if (cmd.ctrl_key) begin
          control_next = 1'b1;
        end
      end
      OP_PORT_READ: begin
        if (cmd.port_hit) begin
          data_next = columns[cmd.port_col];
          if (cmd.release_col) begin
            columns_next[cmd.port_col] = ColIdle;
          end
        end
      end
      default: begin
        for (int i = 0; i < NumColumns; i++) columns_next[i] = ColIdle;
        control_next = 1'b1;
        shift_next   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumColumns; i++) columns[i] <= ColIdle;
      control_level <= 1'b1;
      shift_level   <= 1'b1;
      result_valid  <= 1'b0;
    end else begin
      if (cmd_take) begin
        columns       <= columns_next;
        control_level <= control_next;
        shift_level   <= shift_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      read_data    <= data_next;
      control_line <= control_next;
      shift_line   <= shift_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/key_matrix_scanner_unit.sv =====
// Key matrix scanner top level: front decoder, command queue, back end.
// Depends on kms_pkg, kms_front, kms_queue and kms_back.
//
// Every accepted item yields exactly one result, in order. Items are taken one
// per clock while item_stall is low; an accepted item is stored in the command
// queue and then its result is registered in the result register, which holds
// it while the output is stalled. The command queue of QueueDepth entries lets
// the input keep flowing while a finished result waits; item_stall rises only
// when it is full.
`default_nettype none

module key_matrix_scanner_unit import kms_pkg::*; #(
  parameter int QueueDepth = QueueDepthDf
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] operation,
  input  wire logic [8:0] key_code,
  input  wire logic [2:0] port_number,
  input  wire logic [3:0] cpu_reg3_top_nibble,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      read_data,
  output logic            control_line,
  output logic            shift_line
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  kms_front u_front (
    .operation          (operation),
    .key_code           (key_code),
    .port_number        (port_number),
    .cpu_reg3_top_nibble(cpu_reg3_top_nibble),
    .cmd                (front_cmd)
  );

  kms_queue #(.Depth(QueueDepth)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (item_valid),
    .push_cmd(front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (head_cmd)
  );

  kms_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_ready   (!q_empty),
    .cmd         (head_cmd),
    .cmd_take    (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .read_data   (read_data),
    .control_line(control_line),
    .shift_line  (shift_line)
  );

  assign item_stall = q_full;

endmodule

`default_nettype wire

// ===== sv/kms_checker.sv =====
// Port-level checker for the key matrix scanner, bound to the top level.
// Depends on key_matrix_scanner_unit.
`default_nettype none

module kms_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [7:0] read_data,
  input wire logic       control_line,
  input wire logic       shift_line
);

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !item_stall)
    else $error("input stalled right after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(read_data)
      && $stable(control_line) && $stable(shift_line))
    else $error("stalled result changed");

  a_lone_item_not_stalled: assert property (@(posedge clk) disable iff (rst)
    !item_valid && !result_valid |=> !item_stall)
    else $error("input stalled with queue drained");

endmodule

bind key_matrix_scanner_unit kms_checker u_kms_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .read_data   (read_data),
  .control_line(control_line),
  .shift_line  (shift_line)
);

`default_nettype wire

// ===== tb/key_matrix_scanner_unit_test.sv =====
// Self-checking testbench for key_matrix_scanner_unit: directed and random key
// events, port reads and reset-all items, random idling on both channels, in-order result checks.
// Depends on kms_pkg and the key_matrix_scanner_unit RTL.

module key_matrix_scanner_unit_test import kms_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       hit;
    logic [2:0] col;
    logic [7:0] mask;
  } key_slot_t;

  typedef struct packed {
    logic [7:0] data;
    logic       ctl;
    logic       shift;
  } kbd_reading_t;

  typedef struct packed {
    op_t        op;
    logic [8:0] code;
    logic [2:0] port;
    logic [3:0] nib;
  } kbd_item_t;

  class kbd_scoreboard;
    logic [7:0]   cols [1:5];
    logic         ctl_level;
    logic         shift_level;
    kbd_reading_t expected_reads[$];
    int           n_items, n_checked, n_errors, n_presses, n_reads, n_released;

    function new();
      clear_keys();
      n_items = 0;
      n_checked = 0;
      n_errors = 0;
      n_presses = 0;
      n_reads = 0;
      n_released = 0;
    endfunction

    function void clear_keys();
      for (int i = 1; i <= 5; i++) cols[i] = 8'hff;
      ctl_level = 1'b1;
      shift_level = 1'b1;
    endfunction

    // columns are 1-based here, as the ports number them
    function key_slot_t decode(logic [8:0] code);
      key_slot_t k;
      k = '{1'b0, 3'd0, 8'hff};
      case (code)
        9'd49: k = '{1'b1, 3'd5, 8'hfe};  // '1'
        9'd50: k = '{1'b1, 3'd4, 8'hfe};
        9'd51: k = '{1'b1, 3'd3, 8'hfe};
        9'd52: k = '{1'b1, 3'd2, 8'hfe};
        9'd53: k = '{1'b1, 3'd1, 8'hfe};
        9'd81: k = '{1'b1, 3'd5, 8'hfd};  // 'Q'
        9'd87: k = '{1'b1, 3'd4, 8'hfd};
        9'd69: k = '{1'b1, 3'd3, 8'hfd};
        9'd82: k = '{1'b1, 3'd2, 8'hfd};
        9'd84: k = '{1'b1, 3'd1, 8'hfd};
        9'd65: k = '{1'b1, 3'd5, 8'hfb};  // 'A'
        9'd83: k = '{1'b1, 3'd4, 8'hfb};
        9'd68: k = '{1'b1, 3'd3, 8'hfb};
        9'd70: k = '{1'b1, 3'd2, 8'hfb};
        9'd71: k = '{1'b1, 3'd1, 8'hfb};
        9'd90: k = '{1'b1, 3'd5, 8'hf7};  // 'Z'
        9'd88: k = '{1'b1, 3'd4, 8'hf7};
        9'd67: k = '{1'b1, 3'd3, 8'hf7};
        9'd86: k = '{1'b1, 3'd2, 8'hf7};
        9'd66: k = '{1'b1, 3'd1, 8'hf7};
        9'd54: k = '{1'b1, 3'd1, 8'h7f};  // '6'
        9'd55: k = '{1'b1, 3'd2, 8'h7f};
        9'd56: k = '{1'b1, 3'd3, 8'h7f};
        9'd57: k = '{1'b1, 3'd4, 8'h7f};
        9'd48: k = '{1'b1, 3'd5, 8'h7f};
        9'd89: k = '{1'b1, 3'd1, 8'hbf};  // 'Y'
        9'd85: k = '{1'b1, 3'd2, 8'hbf};
        9'd73: k = '{1'b1, 3'd3, 8'hbf};
        KeyUp: k = '{1'b1, 3'd3, 8'hbf};
        9'd79: k = '{1'b1, 3'd4, 8'hbf};
        9'd80: k = '{1'b1, 3'd5, 8'hbf};
        9'd72: k = '{1'b1, 3'd1, 8'hdf};  // 'H'
        9'd74: k = '{1'b1, 3'd2, 8'hdf};
        KeyLeft: k = '{1'b1, 3'd2, 8'hdf};
        9'd75: k = '{1'b1, 3'd3, 8'hdf};
        KeyRight: k = '{1'b1, 3'd3, 8'hdf};
        9'd76: k = '{1'b1, 3'd4, 8'hdf};
        KeyReturn: k = '{1'b1, 3'd5, 8'hdf};
        9'd78: k = '{1'b1, 3'd1, 8'hef};  // 'N'
        9'd77: k = '{1'b1, 3'd2, 8'hef};
        KeyDown: k = '{1'b1, 3'd2, 8'hef};
        9'd46: k = '{1'b1, 3'd3, 8'hef};  // '.'
        KeySpace: k = '{1'b1, 3'd4, 8'hef};
        KeyBack: k = '{1'b1, 3'd5, 8'hef};
        default: k = '{1'b0, 3'd0, 8'hff};
      endcase
      return k;
    endfunction

    function void note_item(op_t op, logic [8:0] code, logic [2:0] port, logic [3:0] nib);
      key_slot_t    k;
      kbd_reading_t r;
      r.data = 8'hff;
      n_items++;
      case (op)
        OP_KEY_DOWN: begin
          n_presses++;
          if (code == KeyShift) begin
            shift_level = 1'b0;
          end else if (code == KeyCtrl) begin
            ctl_level = 1'b0;
          end else begin
            k = decode(code);
            if (k.hit) cols[k.col] = cols[k.col] & k.mask;
          end
        end
        OP_KEY_UP: begin
          for (int i = 1; i <= 5; i++) cols[i] = 8'hff;
          if (code == KeyShift) shift_level = 1'b1;
          else if (code == KeyCtrl) ctl_level = 1'b1;
        end
        OP_PORT_READ: begin
          n_reads++;
          if (port >= 3'd1 && port <= 3'd5) begin
            r.data = cols[port];
            if (nib == 4'd0) begin
              cols[port] = 8'hff;
              n_released++;
            end
          end
        end
        default: clear_keys();
      endcase
      r.ctl = ctl_level;
      r.shift = shift_level;
      expected_reads.push_back(r);
    endfunction

    function void check_result(logic [7:0] data, logic ctl, logic sh);
      kbd_reading_t e;
      n_checked++;
      if (expected_reads.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("tb: result with nothing pending: data=%02h ctl=%b shift=%b",
                   data, ctl, sh);
        return;
      end
      e = expected_reads.pop_front();
      if (data !== e.data || ctl !== e.ctl || sh !== e.shift) begin
        n_errors++;
        if (n_errors <= 10)
          $display({"tb: mismatch on result %0d: expected data=%02h ctl=%b shift=%b,",
                    " got data=%02h ctl=%b shift=%b"},
                   n_checked, e.data, e.ctl, e.shift, data, ctl, sh);
      end
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] operation = 2'd0;
  logic [8:0] key_code = 9'd0;
  logic [2:0] port_number = 3'd0;
  logic [3:0] cpu_reg3_top_nibble = 4'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] read_data;
  logic       control_line;
  logic       shift_line;

  kbd_scoreboard sb;
  kbd_item_t     stim[$];
  logic [8:0]    key_pool[$];
  int            n_accepted = 0;

  key_matrix_scanner_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .item_valid          (item_valid),
    .item_stall          (item_stall),
    .operation           (operation),
    .key_code            (key_code),
    .port_number         (port_number),
    .cpu_reg3_top_nibble (cpu_reg3_top_nibble),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .read_data           (read_data),
    .control_line        (control_line),
    .shift_line          (shift_line)
  );

  always #2 clk = ~clk;

  // percent chance of starting an idle burst; none near the end
  function automatic int idle_share(int done, int total);
    if (total - done < 100) return 0;
    case ((done / 70) % 3)
      0: return 30;
      1: return 0;
      default: return 60;
    endcase
  endfunction

  function automatic void add_item(op_t op, logic [8:0] code, logic [2:0] port, logic [3:0] nib);
    kbd_item_t it;
    it.op = op;
    it.code = code;
    it.port = port;
    it.nib = nib;
    stim.push_back(it);
  endfunction

  function automatic void build_stimulus(int n_random);
    int         r;
    op_t        op;
    logic [8:0] code;
    logic [2:0] port;
    logic [3:0] nib;
    key_slot_t  k;
    for (int c = 0; c < 512; c++) begin
      k = sb.decode(c[8:0]);
      if (k.hit) key_pool.push_back(c[8:0]);
    end
    add_item(OP_KEY_DOWN, 9'd81, 3'd0, 4'd0);    // 'Q' -> column 5
    add_item(OP_KEY_DOWN, 9'd53, 3'd7, 4'd15);   // '5' -> column 1
    add_item(OP_KEY_DOWN, KeyShift, 3'd0, 4'd0);
    add_item(OP_KEY_DOWN, KeyCtrl, 3'd0, 4'd0);
    add_item(OP_PORT_READ, 9'd0, 3'd5, 4'd15);   // held on read
    add_item(OP_PORT_READ, 9'd0, 3'd5, 4'd0);    // released on read
    add_item(OP_PORT_READ, 9'd511, 3'd5, 4'd0);
    add_item(OP_PORT_READ, 9'd0, 3'd1, 4'd15);
    add_item(OP_KEY_DOWN, 9'd0, 3'd0, 4'd0);     // unknown codes
    add_item(OP_KEY_DOWN, 9'd511, 3'd7, 4'd15);
    add_item(OP_PORT_READ, 9'd0, 3'd0, 4'd0);    // unmapped ports
    add_item(OP_PORT_READ, 9'd0, 3'd6, 4'd0);
    add_item(OP_PORT_READ, 9'd511, 3'd7, 4'd15);
    add_item(OP_KEY_DOWN, 9'd65, 3'd0, 4'd0);    // 'A'
    add_item(OP_KEY_UP, 9'd65, 3'd0, 4'd0);      // ordinary release
    add_item(OP_PORT_READ, 9'd0, 3'd5, 4'd0);
    add_item(OP_KEY_UP, KeyShift, 3'd0, 4'd0);
    add_item(OP_KEY_UP, KeyCtrl, 3'd0, 4'd0);
    add_item(OP_KEY_DOWN, KeyShift, 3'd0, 4'd0);
    add_item(OP_KEY_DOWN, 9'd73, 3'd0, 4'd0);    // 'I'
    add_item(OP_RESET_ALL, 9'd511, 3'd7, 4'd15);
    add_item(OP_PORT_READ, 9'd0, 3'd3, 4'd0);
    add_item(OP_KEY_DOWN, KeyUp, 3'd0, 4'd0);
    add_item(OP_KEY_DOWN, KeyBack, 3'd0, 4'd0);
    add_item(OP_PORT_READ, 9'd0, 3'd3, 4'd8);
    add_item(OP_PORT_READ, 9'd0, 3'd5, 4'd0);
    for (int i = 0; i < n_random; i++) begin
      r = $urandom_range(0, 99);
      code = 9'($urandom_range(0, 511));
      port = 3'($urandom_range(0, 7));
      nib = 4'($urandom_range(0, 15));
      if (r < 42) begin
        op = OP_KEY_DOWN;
        if ($urandom_range(0, 9) == 0)
          code = $urandom_range(0, 1) ? KeyShift : KeyCtrl;
        else if ($urandom_range(0, 4) != 0)
          code = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (r < 54) begin
        op = OP_KEY_UP;
        if ($urandom_range(0, 4) < 3)
          code = $urandom_range(0, 1) ? KeyShift : KeyCtrl;
      end else if (r < 95) begin
        op = OP_PORT_READ;
        if ($urandom_range(0, 4) != 0) port = 3'($urandom_range(1, 5));
        if ($urandom_range(0, 1) == 0) nib = 4'd0;
      end else begin
        op = OP_RESET_ALL;
      end
      add_item(op, code, port, nib);
    end
  endfunction

  task automatic drive_items();
    int        next_idx;
    int        gap;
    bit        presenting;
    kbd_item_t it;
    next_idx = 0;
    gap = 0;
    presenting = 1'b0;
    while (n_accepted < stim.size()) begin
      @(posedge clk);
      if (item_valid && !item_stall) begin
        sb.note_item(op_t'(operation), key_code, port_number, cpu_reg3_top_nibble);
        n_accepted++;
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (gap > 0) begin
          gap--;
          item_valid <= 1'b0;
        end else if (next_idx < stim.size()) begin
          it = stim[next_idx];
          operation <= it.op;
          key_code <= it.code;
          port_number <= it.port;
          cpu_reg3_top_nibble <= it.nib;
          item_valid <= 1'b1;
          presenting = 1'b1;
          next_idx++;
          if ($urandom_range(0, 99) < idle_share(next_idx, stim.size()))
            gap = $urandom_range(1, 11);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall)
        sb.check_result(read_data, control_line, shift_line);
      if (hold > 0) begin
        hold--;
        result_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_share(sb.n_checked, stim.size())) begin
        hold = $urandom_range(1, 11) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int waited;
    sb = new();
    build_stimulus(600);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    drive_items();
    waited = 0;
    while (sb.pending() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() > 0) begin
      $display("tb: %0d results never arrived", sb.pending());
      sb.n_errors += sb.pending();
    end
    $display("summary: %0d items in, %0d results checked, %0d errors",
             sb.n_items, sb.n_checked, sb.n_errors);
    $display("summary: %0d key presses, %0d port reads, %0d reads that released a column",
             sb.n_presses, sb.n_reads, sb.n_released);
    if (sb.n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== key_matrix_scanner_unit.f =====
sv/kms_pkg.sv
sv/kms_front.sv
sv/kms_queue.sv
sv/kms_back.sv
sv/key_matrix_scanner_unit.sv
sv/kms_checker.sv
tb/key_matrix_scanner_unit_test.sv
